// File: src/phcp_pkg.sv
// Shared constants and result status codes for the packet header checksum parser.
// No dependencies.
package phcp_pkg;

  localparam int unsigned POS_W = 6;
  localparam int unsigned LEN_W = 5;
  localparam int unsigned CNT_W = 4;

  localparam logic [POS_W-1:0] POS_SAT   = 6'd36;
  localparam logic [POS_W-1:0] HDR_BYTES = 6'd4;

  localparam logic [POS_W-1:0] POS_SRC   = 6'd0;
  localparam logic [POS_W-1:0] POS_DST   = 6'd1;
  localparam logic [POS_W-1:0] POS_FLAGS = 6'd2;
  localparam logic [POS_W-1:0] POS_LEN   = 6'd3;

  localparam logic [7:0] BANG  = 8'h21;
  localparam logic [7:0] QUEST = 8'h3F;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_MISMATCH  = 2'd1;
  localparam status_t ST_TOO_SHORT = 2'd2;
  localparam status_t ST_BAD_LEN   = 2'd3;

endpackage

// File: src/packet_header_checksum_parser_unit.sv
// Top level of the packet header checksum parser: byte-wide frame in, one result per frame.
// Depends on phcp_pkg.
//
// Path: an accepted byte goes into the input register; a final byte's result is then
//   registered and shown on out_valid (two register stages end to end).
// Throughput: one byte per cycle sustained; the only stall is a final byte waiting for
//   the result register to drain. Set by the single per-byte update of the frame state.
// Reset: rst (synchronous, active high) clears all valid bits and the frame state.
module packet_header_checksum_parser_unit
  import phcp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,

  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           data_byte,
  input  logic                 frame_end,

  output logic                 out_valid,
  input  logic                 out_ready,
  output status_t              status,
  output logic [7:0]           source_id,
  output logic [7:0]           dest_id,
  output logic                 syn_flag,
  output logic                 ack_flag,
  output logic                 urgent_flag,
  output logic [LEN_W-1:0]     payload_len,
  output logic [CNT_W-1:0]     pair_count,
  output logic [7:0]           computed_check,
  output logic [7:0]           received_check
);

  // Input register: one item of lookahead so the link never waits on the state update.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;

  // Frame state.
  logic [POS_W-1:0] pos;
  logic [7:0]       src;
  logic [7:0]       dst;
  logic [2:0]       flags;   // {urgent, ack, syn}
  logic [LEN_W-1:0] len;
  logic [7:0]       xacc;
  logic             bang;
  logic [CNT_W-1:0] pairs;

  logic [POS_W-1:0] pos_next;
  logic [7:0]       src_next;
  logic [7:0]       dst_next;
  logic [2:0]       flags_next;
  logic [LEN_W-1:0] len_next;
  logic [7:0]       xacc_next;
  logic             bang_next;
  logic [CNT_W-1:0] pairs_next;

  logic             adv;          // s1 item consumed this cycle
  logic [POS_W-1:0] payload_end;  // first position after the payload
  logic             in_payload;
  logic             too_short;
  logic             bad_len;

  // A final byte may only move on when the result register is free or being drained.
  assign adv      = s1_valid && (!s1_last || !out_valid || out_ready);
  assign in_ready = !s1_valid || adv;

  assign payload_end = HDR_BYTES + {1'b0, len};
  assign in_payload  = (pos >= HDR_BYTES) && !s1_last && (pos < payload_end);
  // Fewer than five bytes means the final byte sits at position 3 or lower.
  assign too_short   = (pos < HDR_BYTES);
  // No room left for the checksum byte after the payload.
  assign bad_len     = (pos < payload_end);

  always_comb begin
    src_next   = src;
    dst_next   = dst;
    flags_next = flags;
    len_next   = len;
    xacc_next  = xacc;
    bang_next  = bang;
    pairs_next = pairs;
    pos_next   = (pos < POS_SAT) ? pos + 6'd1 : pos;

    case (pos)
      POS_SRC:   src_next   = s1_byte;
      POS_DST:   dst_next   = s1_byte;
      POS_FLAGS: flags_next = {s1_byte[7], s1_byte[1], s1_byte[0]};
      POS_LEN:   len_next   = s1_byte[7:3];
      default: begin
        if (in_payload) begin
          xacc_next = xacc ^ s1_byte;
          if (bang && (s1_byte == QUEST) && (pairs < CNT_MAX)) begin
            pairs_next = pairs + 4'd1;
          end
          bang_next = (s1_byte == BANG);
        end
      end
    endcase

    // Final byte closes the frame: start clean for the next one.
    if (s1_last) begin
      pos_next   = '0;
      src_next   = '0;
      dst_next   = '0;
      flags_next = '0;
      len_next   = '0;
      xacc_next  = '0;
      bang_next  = 1'b0;
      pairs_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_byte <= data_byte;
      s1_last <= frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      src   <= '0;
      dst   <= '0;
      flags <= '0;
      len   <= '0;
      xacc  <= '0;
      bang  <= 1'b0;
      pairs <= '0;
    end else if (adv) begin
      pos   <= pos_next;
      src   <= src_next;
      dst   <= dst_next;
      flags <= flags_next;
      len   <= len_next;
      xacc  <= xacc_next;
      bang  <= bang_next;
      pairs <= pairs_next;
    end
  end

  // Result register. Error results carry only the status code.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (adv && s1_last) begin
      if (too_short || bad_len) begin
        status         <= too_short ? ST_TOO_SHORT : ST_BAD_LEN;
        source_id      <= '0;
        dest_id        <= '0;
        syn_flag       <= 1'b0;
        ack_flag       <= 1'b0;
        urgent_flag    <= 1'b0;
        payload_len    <= '0;
        pair_count     <= '0;
        computed_check <= '0;
        received_check <= '0;
      end else begin
        status         <= (xacc == s1_byte) ? ST_OK : ST_MISMATCH;
        source_id      <= src;
        dest_id        <= dst;
        syn_flag       <= flags[0];
        ack_flag       <= flags[1];
        urgent_flag    <= flags[2];
        payload_len    <= len;
        pair_count     <= pairs;
        computed_check <= xacc;
        received_check <= s1_byte;
      end
    end
  end

`ifndef SYNTH
  a_pos_sat : assert property (@(posedge clk) disable iff (rst) pos <= POS_SAT)
    else $error("byte position past saturation");

  a_frame_clear : assert property (@(posedge clk) disable iff (rst)
    adv && s1_last |=> pos == '0 && xacc == '0 && pairs == '0 && len == '0)
    else $error("frame state not cleared after final byte");

  a_ok_check : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_OK |-> computed_check == received_check)
    else $error("valid status with differing checksums");

  a_mismatch_check : assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_MISMATCH |-> computed_check != received_check)
    else $error("mismatch status with equal checksums");

  a_err_zero : assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_TOO_SHORT || status == ST_BAD_LEN) |->
      source_id == '0 && dest_id == '0 && payload_len == '0 && computed_check == '0)
    else $error("error result carries nonzero fields");

  a_pairs_bound : assert property (@(posedge clk) disable iff (rst)
    {1'b0, pairs} <= len)
    else $error("pair count exceeds payload length");
`endif

endmodule

// File: sim/tb_top.sv
// Testbench for packet_header_checksum_parser_unit: byte frames in, one result per frame out.
// Depends on phcp_pkg and the parser RTL; a class predicts and checks the per-frame results.
module tb_top
  import phcp_pkg::*;
();

  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_PCT      = 36;      // percent of cycles each side sits idle
  localparam int RANDOM_BYTES  = 1000;
  localparam int CALM_FIRST    = 400;     // random bytes [CALM_FIRST, CALM_LAST) run with no idling
  localparam int CALM_LAST     = 600;
  localparam int MIN_FRAME_LEN = 5;
  localparam int DRAIN_CYCLES  = 10;
  localparam int MAX_REPORTS   = 10;
  localparam int CYCLE_LIMIT   = 200000;

  // Field order matches the output port order, so a port concatenation casts straight in.
  typedef struct packed {
    status_t          status;
    logic [7:0]       source_id;
    logic [7:0]       dest_id;
    logic             syn_flag;
    logic             ack_flag;
    logic             urgent_flag;
    logic [LEN_W-1:0] payload_len;
    logic [CNT_W-1:0] pair_count;
    logic [7:0]       computed_check;
    logic [7:0]       received_check;
  } frame_result_t;

  typedef logic [7:0] byte_q_t [$];

  // Tracks the parser's frame state byte by byte and holds the results it owes.
  class frame_result_tracker;
    logic [POS_W-1:0] next_pos;
    logic [7:0]       src;
    logic [7:0]       dst;
    logic [2:0]       flags;      // {URGENT, ACK, SYN}
    logic [LEN_W-1:0] len;
    logic [7:0]       xsum;
    bit               prev_bang;
    logic [CNT_W-1:0] pairs;
    frame_result_t    owed[$];
    int               errors;

    function new();
      clear_frame();
      errors = 0;
    endfunction

    function void clear_frame();
      next_pos  = '0;
      src       = '0;
      dst       = '0;
      flags     = '0;
      len       = '0;
      xsum      = '0;
      prev_bang = 1'b0;
      pairs     = '0;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      logic [POS_W-1:0] p;
      frame_result_t    r;
      p = next_pos;
      if (p == POS_SRC) begin
        src = b;
      end else if (p == POS_DST) begin
        dst = b;
      end else if (p == POS_FLAGS) begin
        flags = {b[7], b[1], b[0]};
      end else if (p == POS_LEN) begin
        len = b[7:3];
      end else if (!last && p < HDR_BYTES + len) begin
        xsum ^= b;
        if (prev_bang && b == QUEST && pairs < CNT_MAX) pairs++;
        prev_bang = (b == BANG);
      end
      if (!last) begin
        if (next_pos < POS_SAT) next_pos++;
        return;
      end
      r = '0;
      if (int'(p) + 1 < MIN_FRAME_LEN) begin
        r.status = ST_TOO_SHORT;
      end else if (p < HDR_BYTES + len) begin
        r.status = ST_BAD_LEN;
      end else begin
        r.status         = (xsum == b) ? ST_OK : ST_MISMATCH;
        r.source_id      = src;
        r.dest_id        = dst;
        r.syn_flag       = flags[0];
        r.ack_flag       = flags[1];
        r.urgent_flag    = flags[2];
        r.payload_len    = len;
        r.pair_count     = pairs;
        r.computed_check = xsum;
        r.received_check = b;
      end
      owed.push_back(r);
      clear_frame();
    endfunction

    function string fmt(frame_result_t r);
      return $sformatf("st=%0d src=%h dst=%h syn=%b ack=%b urg=%b len=%0d pairs=%0d calc=%h rcv=%h",
                       r.status, r.source_id, r.dest_id, r.syn_flag, r.ack_flag, r.urgent_flag,
                       r.payload_len, r.pair_count, r.computed_check, r.received_check);
    endfunction

    function void check_result(frame_result_t got);
      frame_result_t want;
      if (owed.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS) $display("unexpected result: %s", fmt(got));
        return;
      end
      want = owed.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("result mismatch: exp %s", fmt(want));
          $display("                 got %s", fmt(got));
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic             in_valid  = 1'b0;
  logic             in_ready;
  logic [7:0]       data_byte = 8'h00;
  logic             frame_end = 1'b0;

  logic             out_valid;
  logic             out_ready = 1'b0;
  status_t          status;
  logic [7:0]       source_id;
  logic [7:0]       dest_id;
  logic             syn_flag;
  logic             ack_flag;
  logic             urgent_flag;
  logic [LEN_W-1:0] payload_len;
  logic [CNT_W-1:0] pair_count;
  logic [7:0]       computed_check;
  logic [7:0]       received_check;

  frame_result_tracker tracker;
  bit                  calm         = 1'b0;  // both sides stop idling while set
  bit                  random_phase = 1'b0;
  int                  random_sent  = 0;
  int                  cycle_count  = 0;

  packet_header_checksum_parser_unit dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .frame_end      (frame_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .source_id      (source_id),
    .dest_id        (dest_id),
    .syn_flag       (syn_flag),
    .ack_flag       (ack_flag),
    .urgent_flag    (urgent_flag),
    .payload_len    (payload_len),
    .pair_count     (pair_count),
    .computed_check (computed_check),
    .received_check (received_check)
  );

  // 8-unit clock period.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hard stop in case the handshake locks up.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side: random back-pressure, except during the calm stretch.
  always @(posedge clk) begin
    out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // Outputs are sampled at the edge, before any register update lands.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      tracker.check_result(frame_result_t'({status, source_id, dest_id, syn_flag, ack_flag,
                                            urgent_flag, payload_len, pair_count,
                                            computed_check, received_check}));
    end
  end

  // Offer one byte, with random idle cycles ahead of it, and hold it until taken.
  // in_valid stays high between back-to-back items, so it is never lowered and raised
  // in the same step.
  task automatic send_byte(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    data_byte <= b;
    frame_end <= last;
    do @(posedge clk); while (!in_ready);
    tracker.note_byte(b, last);
    if (random_phase) begin
      random_sent++;
      calm <= (random_sent >= CALM_FIRST && random_sent < CALM_LAST);
    end
  endtask

  task automatic send_frame(input byte_q_t frame);
    foreach (frame[i]) send_byte(frame[i], i == frame.size() - 1);
  endtask

  // Mostly well-formed frames with random content; some cut short inside the payload,
  // some pure noise. '!' and '?' are weighted up so pairs actually show up.
  function automatic byte_q_t make_frame();
    byte_q_t    f;
    int         kind;
    int         len;
    int         body;
    int         fill;
    logic [7:0] sum;
    logic [7:0] b;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 6)) f.push_back(8'($urandom_range(0, 255)));
      return f;
    end
    len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 8);
    if (kind >= 75 && len == 0) len = 1;
    repeat (3) f.push_back(8'($urandom_range(0, 255)));
    f.push_back({5'(len), 3'($urandom_range(0, 7))});
    body = (kind >= 75) ? $urandom_range(0, len - 1) : len;
    sum = '0;
    repeat (body) begin
      case ($urandom_range(0, 3))
        0:       b = BANG;
        1:       b = QUEST;
        default: b = 8'($urandom_range(0, 255));
      endcase
      sum ^= b;
      f.push_back(b);
    end
    if (kind < 75) begin
      // occasional long filler pushes the position counter into saturation
      fill = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 24) : $urandom_range(0, 3);
      repeat (fill) f.push_back(8'($urandom_range(0, 255)));
      f.push_back(($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : sum);
    end else begin
      f.push_back(8'($urandom_range(0, 255)));   // final byte lands inside the payload
    end
    return f;
  endfunction

  initial begin
    byte_q_t f;
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // single-byte frame: too short
    f = {8'hFF};
    send_frame(f);
    // four bytes, one short of the minimum
    f = {8'h00, 8'h00, 8'h00, 8'h00};
    send_frame(f);
    // empty payload, all flag bits set, one filler byte, good checksum
    f = {8'hFF, 8'hFF, 8'h83, 8'h07, 8'h5A, 8'h00};
    send_frame(f);
    // length 1 but the frame ends right where the payload byte should be
    f = {8'h12, 8'h34, 8'h01, 8'h08, 8'hAB};
    send_frame(f);
    // length 1, checksum wrong
    f = {8'hAA, 8'h55, 8'h02, 8'h08, 8'h21, 8'h00};
    send_frame(f);
    // '!' '!' '?' payload: one pair, good checksum
    f = {8'h01, 8'h80, 8'h80, 8'h18, 8'h21, 8'h21, 8'h3F, 8'h3F};
    send_frame(f);

    random_phase = 1'b1;
    while (random_sent < RANDOM_BYTES) send_frame(make_frame());
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (tracker.owed.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.errors == 0 && tracker.owed.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
src/phcp_pkg.sv
src/packet_header_checksum_parser_unit.sv
sim/tb_top.sv
